// ===== rtl/core/tlgf_pkg.sv =====
// shared types, constants and command/status structs for the text line glyph frame buffer
// used by tlgf_ctrl, tlgf_dp, the top level and the checker
package tlgf_pkg;

  localparam int COLUMNS_DEF      = 128;
  localparam int GLYPH_COUNT_DEF  = 95;
  localparam int GLYPH_BYTES_DEF  = 25;
  localparam int GLYPH_COLS_DEF   = 12;
  localparam int CURSOR_LIMIT_DEF = 127;

  localparam logic [2:0] KIND_FONT    = 3'd0;
  localparam logic [2:0] KIND_LINE    = 3'd1;
  localparam logic [2:0] KIND_CHAR    = 3'd2;
  localparam logic [2:0] KIND_REFRESH = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

  localparam logic [7:0] CMD_COL_LO = 8'h00;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;

  localparam logic [7:0] SYM_FIRST = 8'd32;
  localparam logic [7:0] SYM_LAST  = 8'd126;

  typedef struct packed {
    logic [2:0]  kind;
    logic        line;
    logic [7:0]  symbol;
    logic [11:0] font_addr;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic font_wr;
    logic clr_init;
    logic clr_step;
    logic g_setup;
    logic g_width;
    logic g_wcap;
    logic g_fetch;
    logic g_adv;
    logic ref_rd;
    logic ref_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic draw_ok;
    logic glyph_busy;
  } dp_status_t;

endpackage

// ===== rtl/core/tlgf_ctrl.sv =====
// sequencing state machine: decodes accepted items into datapath commands
// depends on tlgf_pkg
module tlgf_ctrl
  import tlgf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] kind,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FONT,
    S_CLR_INIT,
    S_CLEAR,
    S_G_SETUP,
    S_G_WIDTH,
    S_G_WCAP,
    S_G_RUN,
    S_G_ADV,
    S_R_RD,
    S_R_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_FONT) state_nxt = S_FONT;
          else if (kind == KIND_LINE || kind == KIND_CLEAR) state_nxt = S_CLR_INIT;
          else if (kind == KIND_CHAR) state_nxt = S_G_SETUP;
          else if (kind == KIND_REFRESH) state_nxt = S_R_RD;
          else state_nxt = S_IDLE;
        end
      end
      S_FONT:     state_nxt = S_IDLE;
      S_CLR_INIT: state_nxt = S_CLEAR;
      S_CLEAR:    state_nxt = status.clr_last ? S_IDLE : S_CLEAR;
      S_G_SETUP:  state_nxt = status.draw_ok ? S_G_WIDTH : S_IDLE;
      S_G_WIDTH:  state_nxt = S_G_WCAP;
      S_G_WCAP:   state_nxt = S_G_RUN;
      S_G_RUN:    state_nxt = status.glyph_busy ? S_G_RUN : S_G_ADV;
      S_G_ADV:    state_nxt = S_IDLE;
      S_R_RD:     state_nxt = S_R_OUT;
      S_R_OUT:    state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && start;
    cmd.font_wr  = (state_r == S_FONT);
    cmd.clr_init = (state_r == S_CLR_INIT);
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.g_setup  = (state_r == S_G_SETUP);
    cmd.g_width  = (state_r == S_G_WIDTH);
    cmd.g_wcap   = (state_r == S_G_WCAP);
    cmd.g_fetch  = (state_r == S_G_RUN);
    cmd.g_adv    = (state_r == S_G_ADV);
    cmd.ref_rd   = (state_r == S_R_RD);
    cmd.ref_out  = (state_r == S_R_OUT);
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/tlgf_dp.sv =====
// datapath: frame store, font store, cursors, clear sweep, glyph copy and refresh stream
// depends on tlgf_pkg, driven by tlgf_ctrl commands
module tlgf_dp
  import tlgf_pkg::*;
#(
  parameter int COLUMNS      = COLUMNS_DEF,
  parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
  parameter int GLYPH_BYTES  = GLYPH_BYTES_DEF,
  parameter int GLYPH_COLS   = GLYPH_COLS_DEF,
  parameter int CURSOR_LIMIT = CURSOR_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int FRAME_SIZE = 4 * COLUMNS;
  localparam int FA_W       = $clog2(FRAME_SIZE);
  localparam int FONT_SIZE  = GLYPH_COUNT * GLYPH_BYTES;
  localparam int FN_W       = $clog2(FONT_SIZE);
  localparam int CC_W       = $clog2(GLYPH_COLS + 1);
  localparam int KB_W       = $clog2(2 * GLYPH_COLS + 2);
  localparam int RO_W       = $clog2(COLUMNS + 3);
  localparam int OFF_LAST   = COLUMNS + 2;

  localparam logic [RO_W-1:0] OFF_COL_LO = RO_W'(0);
  localparam logic [RO_W-1:0] OFF_COL_HI = RO_W'(1);
  localparam logic [RO_W-1:0] OFF_PAGE   = RO_W'(2);
  localparam logic [RO_W-1:0] OFF_DATA   = RO_W'(3);

  in_item_t        item_r;
  logic [7:0]      cur_top_r, cur_bot_r, cur_sel;
  logic [FN_W-1:0] base_r;
  logic [CC_W-1:0] col_r;
  logic            half_r;
  logic [7:0]      width_r;
  logic            pend_r, pend_zero_r;
  logic [FA_W-1:0] pend_addr_r;
  logic [FA_W-1:0] clr_addr_r, clr_end_r;
  logic [1:0]      rpage_r;
  logic [RO_W-1:0] roff_r;
  logic            rcmd_r, rend_r;
  logic [7:0]      rbyte_r;
  logic            out_valid_r;
  out_item_t       out_r;

  logic [7:0]      font_mem [FONT_SIZE];
  logic [7:0]      frame_mem [FRAME_SIZE];
  logic [7:0]      font_q, frame_q;
  logic            font_we, fr_we;
  logic [FN_W-1:0] font_a;
  logic [FA_W-1:0] fr_a, ref_a, tgt_addr;
  logic [7:0]      fr_d;

  logic [6:0]      idx;
  logic [8:0]      col_abs, adv_sum;
  logic [KB_W-1:0] kb;
  logic            k_zero, done;

  assign cur_sel = item_r.line ? cur_bot_r : cur_top_r;
  assign idx     = 7'(item_r.symbol - SYM_FIRST);
  assign col_abs = {1'b0, cur_sel} + 9'(col_r);
  assign kb      = KB_W'({col_r, half_r}) + KB_W'(1);
  assign k_zero  = (32'(kb) >= GLYPH_BYTES);
  assign done    = (32'(col_r) >= GLYPH_COLS) || (32'(col_abs) >= COLUMNS);
  assign tgt_addr = FA_W'(32'({item_r.line, half_r}) * COLUMNS + 32'(col_abs));
  assign adv_sum = {1'b0, cur_sel} + {1'b0, width_r};

  assign status.clr_last   = (clr_addr_r == clr_end_r);
  assign status.draw_ok    = (item_r.symbol >= SYM_FIRST) && (item_r.symbol <= SYM_LAST) &&
                             (32'(idx) < GLYPH_COUNT) && (32'(cur_sel) < CURSOR_LIMIT);
  assign status.glyph_busy = !done || pend_r;

  // font store port
  always_comb begin
    font_a = base_r + FN_W'(kb);
    if (cmd.font_wr) font_a = FN_W'(item_r.font_addr);
    else if (cmd.g_width) font_a = base_r;
  end
  assign font_we = cmd.font_wr && (32'(item_r.font_addr) < FONT_SIZE);

  always_ff @(posedge clk) begin
    if (font_we) font_mem[font_a] <= item_r.font_byte;
    font_q <= font_mem[font_a];
  end

  // frame store port
  assign ref_a = FA_W'(32'(rpage_r) * COLUMNS + 32'(roff_r) - 32'(OFF_DATA));
  assign fr_we = cmd.clr_step || pend_r;
  always_comb begin
    fr_a = ref_a;
    fr_d = '0;
    priority if (cmd.clr_step) begin
      fr_a = clr_addr_r;
    end else if (pend_r) begin
      fr_a = pend_addr_r;
      fr_d = pend_zero_r ? 8'd0 : font_q;
    end else begin
      fr_a = ref_a;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) frame_mem[fr_a] <= fr_d;
    frame_q <= frame_mem[fr_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.g_setup) base_r <= FN_W'(idx) * FN_W'(GLYPH_BYTES);
    if (cmd.g_wcap) width_r <= font_q;
    if (cmd.g_fetch) begin
      pend_addr_r <= tgt_addr;
      pend_zero_r <= k_zero;
    end
    if (cmd.ref_rd) begin
      rcmd_r  <= (roff_r < OFF_DATA);
      rend_r  <= (rpage_r == 2'd3) && (32'(roff_r) == OFF_LAST);
      rbyte_r <= (roff_r == OFF_COL_LO) ? CMD_COL_LO :
                 (roff_r == OFF_COL_HI) ? CMD_COL_HI :
                 (roff_r == OFF_PAGE)   ? (CMD_PAGE | {6'd0, rpage_r}) : 8'd0;
    end
    if (cmd.ref_out) begin
      out_r.out_byte   <= rcmd_r ? rbyte_r : frame_q;
      out_r.is_command <= rcmd_r;
      out_r.frame_end  <= rend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_top_r   <= '0;
      cur_bot_r   <= '0;
      col_r       <= '0;
      half_r      <= 1'b0;
      pend_r      <= 1'b0;
      clr_addr_r  <= '0;
      clr_end_r   <= FA_W'(FRAME_SIZE - 1);
      rpage_r     <= '0;
      roff_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.ref_out;
      pend_r      <= cmd.g_fetch && !done;
      if (cmd.clr_init) begin
        if (item_r.kind == KIND_LINE) begin
          clr_addr_r <= FA_W'(32'(item_r.line) * 2 * COLUMNS);
          clr_end_r  <= FA_W'(32'(item_r.line) * 2 * COLUMNS + 2 * COLUMNS - 1);
          if (item_r.line) cur_bot_r <= '0;
          else cur_top_r <= '0;
        end else begin
          clr_addr_r <= '0;
          clr_end_r  <= FA_W'(FRAME_SIZE - 1);
        end
      end
      if (cmd.clr_step && !status.clr_last) clr_addr_r <= clr_addr_r + FA_W'(1);
      if (cmd.g_setup) begin
        col_r  <= '0;
        half_r <= 1'b0;
      end
      if (cmd.g_fetch && !done) begin
        half_r <= !half_r;
        if (half_r) col_r <= col_r + CC_W'(1);
      end
      if (cmd.g_adv) begin
        if (item_r.line) cur_bot_r <= adv_sum[8] ? 8'hFF : adv_sum[7:0];
        else cur_top_r <= adv_sum[8] ? 8'hFF : adv_sum[7:0];
      end
      if (cmd.ref_rd) begin
        if (32'(roff_r) == OFF_LAST) begin
          roff_r  <= '0;
          rpage_r <= rpage_r + 2'd1;
        end else begin
          roff_r <= roff_r + RO_W'(1);
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/text_line_glyph_framebuffer.sv =====
// top level of the text line glyph frame buffer: controller plus datapath
// depends on tlgf_pkg, tlgf_ctrl, tlgf_dp
//
// Items are taken when start is high and busy is low; one item is worked at a time. A refresh
// byte appears on out_item with out_valid for one cycle, after its item passes the R_RD and R_OUT states,
// and the receiver cannot hold it off. The single-port frame and font stores take one byte per cycle:
// a character runs setup, width read, width capture, glyph copy and cursor advance (setup only when
// not drawable); start line clears its two pages and clear screen the whole frame in one sweep.
// After reset a clearing pass over the whole frame runs with busy high.
module text_line_glyph_framebuffer
  import tlgf_pkg::*;
#(
  parameter int COLUMNS      = COLUMNS_DEF,
  parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF,
  parameter int GLYPH_BYTES  = GLYPH_BYTES_DEF,
  parameter int GLYPH_COLS   = GLYPH_COLS_DEF,
  parameter int CURSOR_LIMIT = CURSOR_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tlgf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .kind   (in_item.kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  tlgf_dp #(
    .COLUMNS      (COLUMNS),
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_BYTES  (GLYPH_BYTES),
    .GLYPH_COLS   (GLYPH_COLS),
    .CURSOR_LIMIT (CURSOR_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/core/tlgf_checker.sv =====
// port-level checks for text_line_glyph_framebuffer, attached by bind
// depends on tlgf_pkg
module tlgf_checker
  import tlgf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  logic take;
  assign take = start && !busy;

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_item.kind <= KIND_CLEAR) |=> busy)
    else $error("busy not raised after an accepted beat");

  a_refresh_beat: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_item.kind == KIND_REFRESH |-> ##3 out_valid)
    else $error("refresh beat missing");

  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_item.kind != KIND_REFRESH |-> ##3 !out_valid)
    else $error("result beat without refresh request");

  a_single: assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("back to back result beats");

  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.is_command |->
      (out_item.out_byte == CMD_COL_LO || out_item.out_byte == CMD_COL_HI ||
       out_item.out_byte[7:2] == CMD_PAGE[7:2]) && !out_item.frame_end)
    else $error("bad command byte");

endmodule

bind text_line_glyph_framebuffer tlgf_checker u_tlgf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== bench/text_line_glyph_framebuffer_tb.sv =====
// self-checking bench for text_line_glyph_framebuffer: loads glyphs, draws text on both lines
// and checks every refresh beat against a local frame buffer image; depends on tlgf_pkg
`timescale 1ns / 1ps

module text_line_glyph_framebuffer_tb;
  import tlgf_pkg::*;

  localparam int COLS           = COLUMNS_DEF;
  localparam int FONT_BYTES     = GLYPH_COUNT_DEF * GLYPH_BYTES_DEF;
  localparam int PAGE_SPAN      = COLS + 3;
  localparam int STREAM_LEN     = 4 * PAGE_SPAN;
  localparam int DRAIN_CYCLES   = 4 * COLS + 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 80;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  stim_item;
  logic      out_valid;
  out_item_t out_item;

  text_line_glyph_framebuffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (stim_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected frame contents and stream position
  logic [7:0]  frame_img [4 * COLS];
  logic [7:0]  font_img [FONT_BYTES];
  logic [7:0]  line_cursor [2];
  int unsigned stream_pos;
  out_item_t   refresh_beats_due [$];
  int          errors;

  // sender side bookkeeping
  bit          font_written [FONT_BYTES];
  int          loaded_glyphs [$];
  int          burst_left;
  int          quiet_cycles;
  logic [7:0]  zero_sym;
  logic [7:0]  step_sym;
  logic [7:0]  wide_sym;

  initial begin
    foreach (frame_img[i]) frame_img[i] = 8'h00;
    foreach (font_img[i]) font_img[i] = 8'h00;
    line_cursor[0] = 8'd0;
    line_cursor[1] = 8'd0;
    stream_pos     = 0;
    errors         = 0;
    burst_left     = 0;
    quiet_cycles   = 0;
  end

  function automatic logic [7:0] glyph_at(int unsigned base, int unsigned k);
    if (k >= GLYPH_BYTES_DEF || base + k >= FONT_BYTES) return 8'h00;
    return font_img[base + k];
  endfunction

  function automatic bit glyph_ready(logic [7:0] sym);
    int unsigned base;
    if (sym < SYM_FIRST || sym > SYM_LAST) return 1'b1;
    base = (sym - SYM_FIRST) * GLYPH_BYTES_DEF;
    for (int k = 0; k < GLYPH_BYTES_DEF; k++) begin
      if (!font_written[base + k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t item_of(logic [2:0] kind, logic line, logic [7:0] symbol,
                                       logic [11:0] font_addr, logic [7:0] font_byte);
    in_item_t it;
    it.kind      = kind;
    it.line      = line;
    it.symbol    = symbol;
    it.font_addr = font_addr;
    it.font_byte = font_byte;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    if (it.kind == KIND_FONT && it.font_addr < FONT_BYTES) font_written[it.font_addr] = 1'b1;
    start     <= 1'b1;
    stim_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // checks each refresh beat, then advances the local image on each accepted beat
  always @(posedge clk) begin : frame_scoreboard
    out_item_t   want;
    int unsigned base;
    int unsigned col;
    int unsigned pg0;
    int unsigned page;
    int unsigned off;
    int unsigned adv;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (refresh_beats_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected refresh beat, expected none, actual %h", $time, out_item);
        end else begin
          want = refresh_beats_due.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_item.out_byte);
          end
          if (out_item.is_command !== want.is_command) begin
            errors++;
            $display("%0t: is_command expected %b actual %b", $time, want.is_command,
                     out_item.is_command);
          end
          if (out_item.frame_end !== want.frame_end) begin
            errors++;
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                     out_item.frame_end);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        case (stim_item.kind)
          KIND_FONT: begin
            if (stim_item.font_addr < FONT_BYTES)
              font_img[stim_item.font_addr] = stim_item.font_byte;
          end
          KIND_LINE: begin
            pg0 = stim_item.line ? 2 : 0;
            for (int i = 0; i < 2 * COLS; i++) frame_img[pg0 * COLS + i] = 8'h00;
            line_cursor[stim_item.line] = 8'd0;
          end
          KIND_CHAR: begin
            if (stim_item.symbol >= SYM_FIRST && stim_item.symbol <= SYM_LAST &&
                stim_item.symbol - SYM_FIRST < GLYPH_COUNT_DEF &&
                line_cursor[stim_item.line] < CURSOR_LIMIT_DEF) begin
              base = (stim_item.symbol - SYM_FIRST) * GLYPH_BYTES_DEF;
              pg0  = stim_item.line ? 2 : 0;
              for (int c = 0; c < GLYPH_COLS_DEF; c++) begin
                col = line_cursor[stim_item.line] + c;
                // columns past the right side are dropped
                if (col < COLS) begin
                  frame_img[pg0 * COLS + col]       = glyph_at(base, 1 + 2 * c);
                  frame_img[(pg0 + 1) * COLS + col] = glyph_at(base, 2 + 2 * c);
                end
              end
              adv = line_cursor[stim_item.line] + glyph_at(base, 0);
              line_cursor[stim_item.line] = (adv > 255) ? 8'd255 : 8'(adv);
            end
          end
          KIND_REFRESH: begin
            page = stream_pos / PAGE_SPAN;
            off  = stream_pos % PAGE_SPAN;
            if (off == 0) begin
              want.out_byte   = CMD_COL_LO;
              want.is_command = 1'b1;
            end else if (off == 1) begin
              want.out_byte   = CMD_COL_HI;
              want.is_command = 1'b1;
            end else if (off == 2) begin
              want.out_byte   = CMD_PAGE | 8'(page);
              want.is_command = 1'b1;
            end else begin
              want.out_byte   = frame_img[page * COLS + off - 3];
              want.is_command = 1'b0;
            end
            want.frame_end = (stream_pos == STREAM_LEN - 1);
            refresh_beats_due.push_back(want);
            stream_pos = (stream_pos + 1 >= STREAM_LEN) ? 0 : stream_pos + 1;
          end
          KIND_CLEAR: begin
            foreach (frame_img[i]) frame_img[i] = 8'h00;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_line_glyph_framebuffer regression: fail");
      $finish;
    end
  end

  // empty frame, ignored kinds, undrawable symbols, out-of-range font writes
  task automatic test_blank_screen();
    repeat (4) send_item(item_of(KIND_REFRESH, 1'b0, 8'h00, 12'h000, 8'h00));
    send_item(item_of(KIND_FONT, 1'b1, 8'hFF, 12'(FONT_BYTES), 8'hFF));
    send_item(item_of(KIND_FONT, 1'b0, 8'h00, 12'hFFF, 8'hA5));
    send_item(item_of(3'd5, 1'b1, 8'hFF, 12'hFFF, 8'hFF));
    send_item(item_of(3'd6, 1'b0, 8'h41, 12'h123, 8'h5A));
    send_item(item_of(3'd7, 1'b1, 8'h7E, 12'h800, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b0, 8'd0, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b1, 8'd31, 12'hFFF, 8'hFF));
    send_item(item_of(KIND_CHAR, 1'b0, 8'd127, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b1, 8'd255, 12'h000, 8'h00));
    send_item(item_of(KIND_CLEAR, 1'b0, 8'h00, 12'h000, 8'h00));
    send_item(item_of(KIND_LINE, 1'b0, 8'h00, 12'h000, 8'h00));
    send_item(item_of(KIND_LINE, 1'b1, 8'h00, 12'h000, 8'h00));
    repeat (3) send_item(item_of(KIND_REFRESH, 1'b1, 8'hFF, 12'hFFF, 8'hFF));
  endtask

  // loads eight whole glyphs: first and last symbol plus six random ones
  task automatic test_font_load();
    int          idx;
    int unsigned base;
    logic [7:0]  wbyte;
    while (loaded_glyphs.size() < 8) begin
      case (loaded_glyphs.size())
        0: idx = 0;
        1: idx = GLYPH_COUNT_DEF - 1;
        default: idx = $urandom_range(1, GLYPH_COUNT_DEF - 2);
      endcase
      if (!glyph_ready(8'(idx) + SYM_FIRST)) begin
        case (loaded_glyphs.size())
          0: wbyte = 8'd6;
          1: begin
            wbyte    = 8'd255;
            wide_sym = 8'(idx) + SYM_FIRST;
          end
          2: begin
            wbyte    = 8'd0;
            zero_sym = 8'(idx) + SYM_FIRST;
          end
          3: begin
            wbyte    = 8'd10;
            step_sym = 8'(idx) + SYM_FIRST;
          end
          default: wbyte = 8'($urandom_range(1, 14));
        endcase
        base = idx * GLYPH_BYTES_DEF;
        send_item(item_of(KIND_FONT, 1'($urandom), 8'($urandom), 12'(base), wbyte));
        for (int k = 1; k < GLYPH_BYTES_DEF; k++)
          send_item(item_of(KIND_FONT, 1'($urandom), 8'($urandom), 12'(base + k),
                            8'($urandom)));
        loaded_glyphs.push_back(idx);
      end
    end
  endtask

  // cursor saturation, blocked cursor and glyph columns past the right side
  task automatic test_line_edges();
    send_item(item_of(KIND_LINE, 1'b0, 8'h00, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b0, SYM_FIRST, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b0, zero_sym, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b0, wide_sym, 12'h000, 8'h00));
    send_item(item_of(KIND_CHAR, 1'b0, step_sym, 12'h000, 8'h00));
    send_item(item_of(KIND_LINE, 1'b1, 8'h00, 12'h000, 8'h00));
    repeat (14) send_item(item_of(KIND_CHAR, 1'b1, step_sym, 12'h000, 8'h00));
  endtask

  // one full pass of the refresh stream, through the end of frame and the wrap
  task automatic test_frame_sweep();
    repeat (STREAM_LEN + 8)
      send_item(item_of(KIND_REFRESH, 1'($urandom), 8'($urandom), 12'($urandom),
                        8'($urandom)));
  endtask

  task automatic test_random_text();
    in_item_t it;
    int       r;
    int       idx;
    repeat (RANDOM_ITEMS) begin
      it = in_item_t'($urandom);
      r  = $urandom_range(99);
      if (r < 40) begin
        it.kind = KIND_CHAR;
        if ($urandom_range(4) != 0 || !glyph_ready(it.symbol))
          it.symbol = 8'(loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)]) + SYM_FIRST;
      end else if (r < 80) begin
        it.kind = KIND_REFRESH;
      end else if (r < 88) begin
        it.kind = KIND_FONT;
        if ($urandom_range(4) < 3) begin
          idx = loaded_glyphs[$urandom_range(loaded_glyphs.size() - 1)];
          it.font_addr = 12'(idx * GLYPH_BYTES_DEF + $urandom_range(GLYPH_BYTES_DEF - 1));
        end
      end else if (r < 92) begin
        it.kind = KIND_LINE;
      end else if (r < 95) begin
        it.kind = KIND_CLEAR;
      end else begin
        it.kind = 3'($urandom_range(5, 7));
      end
      send_item(it);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    stim_item <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_blank_screen();
    test_font_load();
    test_line_edges();
    test_frame_sweep();
    test_random_text();
    start <= 1'b0;
    while (refresh_beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("text_line_glyph_framebuffer regression: pass");
    end else begin
      $display("text_line_glyph_framebuffer regression: fail");
    end
    $finish;
  end

endmodule
